@@ hw/rtl/bia_pkg.sv @@
package bia_pkg;

   // bitmap geometry
   localparam int unsigned CAPACITY_DEF = 8192;
   localparam int unsigned WORD_W       = 64;
   localparam int unsigned BIT_W        = 6;

   // field widths
   localparam int unsigned ID_W        = 16;
   localparam int unsigned CNT_W       = 17;
   localparam int unsigned COUNT_REG_W = 14;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   // register reset values
   localparam logic [ID_W-1:0]        BASE_RESET  = 16'd300;
   localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 14'd4701;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_ID  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ID_COUNT = 1'b1;

   typedef enum logic {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_WR,
      ST_DONE
   } state_type;

   // lowest usable clear bit of one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } ffz_res_type;

endpackage

@@ hw/rtl/bia_ram.sv @@
module bia_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 128,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [AW-1:0]        raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/bia_ffz.sv @@
module bia_ffz (
   input  logic [bia_pkg::WORD_W-1:0] word,
   input  logic                       full,
   input  logic [bia_pkg::BIT_W-1:0]  lim,
   output bia_pkg::ffz_res_type       res
);

   logic [bia_pkg::WORD_W-1:0] free;

   // a bit is usable below the range limit; the last word is cut at lim
   always_comb begin
      free = '0;
      for (int b = 0; b < int'(bia_pkg::WORD_W); b++) begin
         free[b] = ~word[b] & (full | (bia_pkg::BIT_W'(b) < lim));
      end
   end

   // priority encode, lowest clear bit wins
   always_comb begin
      res.found = |free;
      res.idx   = '0;
      for (int b = int'(bia_pkg::WORD_W) - 1; b >= 0; b--) begin
         if (free[b]) begin
            res.idx = bia_pkg::BIT_W'(b);
         end
      end
   end

endmodule

@@ hw/rtl/bitmap_id_allocator.sv @@
// Allocate: one 64-bit bitmap word is searched per cycle, with a read kept in flight; the
// lowest clear bit in range is set and granted, or status NO_FREE is given when none is free.
// Release: read, modify and write back, result; straight to the result when out of range.
// One item at a time; the next request can be taken in the cycle the response is presented.
// Synchronous reset clears the bitmap with a pass over all CAPACITY/64 words
// (128 words by default), one word per cycle; no word is accepted until it ends.
module bitmap_id_allocator #(
   parameter int unsigned CAPACITY = bia_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bia_pkg::ID_W-1:0]           req_tdata,   // [15:0] release_id
   input  logic                               req_tuser,   // [0] action
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bia_pkg::ID_W-1:0]           rsp_tdata,   // [15:0] granted_id
   output logic [bia_pkg::STATUS_W-1:0]       rsp_tuser,   // [1:0] status
   // register writes
   input  logic                               csr_we,
   input  logic [bia_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bia_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned WORDS  = (CAPACITY + bia_pkg::WORD_W - 1) / bia_pkg::WORD_W;
   localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned WCNT_W = $clog2(WORDS + 1);
   localparam int unsigned HI_W   = bia_pkg::CNT_W - bia_pkg::BIT_W;

   bia_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                     clr_ff, clr_in;
   logic [WCNT_W-1:0]                 addr_ff, addr_in;
   logic                              dv_ff, dv_in;
   logic [AW-1:0]                     dw_ff, dw_in;
   logic [bia_pkg::CNT_W-1:0]         n_ff, n_in;
   logic [WCNT_W-1:0]                 nwords_ff, nwords_in;
   logic [bia_pkg::ID_W-1:0]          rel_k_ff, rel_k_in;
   logic [bia_pkg::ID_W-1:0]          pend_id_ff, pend_id_in;
   bia_pkg::status_type               pend_st_ff, pend_st_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bia_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   bia_pkg::status_type               rsp_st_ff, rsp_st_in;
   logic [bia_pkg::ID_W-1:0]          base_ff, base_in;
   logic [bia_pkg::COUNT_REG_W-1:0]   count_ff, count_in;

   logic                              ram_we, ram_re;
   logic [AW-1:0]                     ram_waddr, ram_raddr;
   logic [bia_pkg::WORD_W-1:0]        ram_wdata, ram_rdata;

   logic [bia_pkg::CNT_W-1:0]         n_eff;
   logic [bia_pkg::CNT_W-1:0]         n_round;
   logic [bia_pkg::ID_W-1:0]          rel_off;
   logic                              rel_ok;
   logic                              accept;
   logic                              slot_free;
   logic                              scan_full;
   bia_pkg::ffz_res_type              ffz_res;

   // effective count: min(id_count, capacity, room left in 16 bits)
   always_comb begin
      n_eff = bia_pkg::CNT_W'(count_ff);
      if (n_eff > bia_pkg::CNT_W'(CAPACITY)) begin
         n_eff = bia_pkg::CNT_W'(CAPACITY);
      end
      if (n_eff > ((bia_pkg::CNT_W'(1) << bia_pkg::ID_W) - bia_pkg::CNT_W'(base_ff))) begin
         n_eff = (bia_pkg::CNT_W'(1) << bia_pkg::ID_W) - bia_pkg::CNT_W'(base_ff);
      end
   end

   assign n_round   = n_eff + bia_pkg::CNT_W'(bia_pkg::WORD_W - 1);
   assign rel_off   = req_tdata - base_ff;
   assign rel_ok    = (req_tdata >= base_ff) && (bia_pkg::CNT_W'(rel_off) < n_eff);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // word search over the data coming back from the bitmap
   assign scan_full = HI_W'(dw_ff) < n_ff[bia_pkg::CNT_W-1:bia_pkg::BIT_W];

   bia_ffz u_ffz (
      .word (ram_rdata),
      .full (scan_full),
      .lim  (n_ff[bia_pkg::BIT_W-1:0]),
      .res  (ffz_res)
   );

   bia_ram #(
      .WIDTH (bia_pkg::WORD_W),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bia_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = bia_pkg::ST_IDLE;
            end
         end
         bia_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == bia_pkg::ACT_ALLOC) begin
                  state_in = bia_pkg::ST_SCAN;
               end else if (rel_ok) begin
                  state_in = bia_pkg::ST_REL_RD;
               end else begin
                  state_in = bia_pkg::ST_DONE;
               end
            end
         end
         bia_pkg::ST_SCAN: begin
            if (dv_ff && ffz_res.found) begin
               state_in = bia_pkg::ST_DONE;
            end else if (!dv_ff && (addr_ff >= nwords_ff)) begin
               state_in = bia_pkg::ST_DONE;
            end
         end
         bia_pkg::ST_REL_RD: state_in = bia_pkg::ST_REL_WR;
         bia_pkg::ST_REL_WR: state_in = bia_pkg::ST_DONE;
         bia_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = bia_pkg::ST_IDLE;
            end
         end
         default: state_in = bia_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and bitmap port
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = dw_ff;
      ram_wdata  = '0;
      ram_re     = 1'b0;
      ram_raddr  = addr_ff[AW-1:0];
      case (state_ff)
         bia_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         bia_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         bia_pkg::ST_SCAN: begin
            ram_re = addr_ff < nwords_ff;
            if (dv_ff && ffz_res.found) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata | (bia_pkg::WORD_W'(1) << ffz_res.idx);
            end
         end
         bia_pkg::ST_REL_RD: begin
            ram_re    = 1'b1;
            ram_raddr = rel_k_ff[AW+bia_pkg::BIT_W-1:bia_pkg::BIT_W];
         end
         bia_pkg::ST_REL_WR: begin
            ram_we    = 1'b1;
            ram_waddr = rel_k_ff[AW+bia_pkg::BIT_W-1:bia_pkg::BIT_W];
            ram_wdata = ram_rdata &
                        ~(bia_pkg::WORD_W'(1) << rel_k_ff[bia_pkg::BIT_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      dv_in        = 1'b0;
      dw_in        = dw_ff;
      n_in         = n_ff;
      nwords_in    = nwords_ff;
      rel_k_in     = rel_k_ff;
      pend_id_in   = pend_id_ff;
      pend_st_in   = pend_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      base_in      = base_ff;
      count_in     = count_ff;

      case (state_ff)
         bia_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         bia_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in    = '0;
               n_in       = n_eff;
               nwords_in  = n_round[WCNT_W+bia_pkg::BIT_W-1:bia_pkg::BIT_W];
               rel_k_in   = rel_off;
               pend_id_in = '0;
               if (req_tuser == bia_pkg::ACT_ALLOC) begin
                  pend_st_in = bia_pkg::STATUS_NO_FREE;
               end else if (rel_ok) begin
                  pend_st_in = bia_pkg::STATUS_OK;
               end else begin
                  pend_st_in = bia_pkg::STATUS_RANGE;
               end
            end
         end
         bia_pkg::ST_SCAN: begin
            // keep one read in flight ahead of the search
            dv_in = ram_re;
            dw_in = addr_ff[AW-1:0];
            if (ram_re) begin
               addr_in = addr_ff + WCNT_W'(1);
            end
            if (dv_ff && ffz_res.found) begin
               dv_in      = 1'b0;
               pend_id_in = base_ff + bia_pkg::ID_W'({dw_ff, ffz_res.idx});
               pend_st_in = bia_pkg::STATUS_OK;
            end
         end
         bia_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = pend_id_ff;
               rsp_st_in    = pend_st_ff;
            end
         end
         default: begin
         end
      endcase

      // register writes
      if (csr_we) begin
         case (csr_addr)
            bia_pkg::CSR_BASE_ID:  base_in  = csr_wdata;
            bia_pkg::CSR_ID_COUNT: count_in = csr_wdata[bia_pkg::COUNT_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bia_pkg::ST_CLEAR;
         clr_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= bia_pkg::BASE_RESET;
         count_ff     <= bia_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      dw_ff      <= dw_in;
      n_ff       <= n_in;
      nwords_ff  <= nwords_in;
      rel_k_ff   <= rel_k_in;
      pend_id_ff <= pend_id_in;
      pend_st_ff <= pend_st_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_st_ff;

   // a nonzero identifier only comes with an ok status
   a_id_zero_unless_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != bia_pkg::STATUS_OK) |-> rsp_tdata == '0)
      else $error("nonzero identifier on a failed or release response");

   // no request taken while the bitmap is being cleared
   a_no_accept_in_clear : assert property (@(posedge clock)
      state_ff == bia_pkg::ST_CLEAR |-> !req_tready)
      else $error("request ready during clearing pass");

   // bitmap written only by clearing, a grant or a release write-back
   a_write_states : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == bia_pkg::ST_CLEAR) || (state_ff == bia_pkg::ST_SCAN)
                 || (state_ff == bia_pkg::ST_REL_WR))
      else $error("bitmap write outside a write state");

   // a grant sets a bit that read back clear
   a_grant_sets_clear_bit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bia_pkg::ST_SCAN) && ram_we |-> ram_wdata != ram_rdata)
      else $error("grant write does not change the bitmap word");

   // scan never reads past the managed words
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bia_pkg::ST_SCAN) && ram_re |-> addr_ff < WCNT_W'(WORDS))
      else $error("scan address beyond bitmap");

endmodule

@@ tb/sv/bitmap_id_allocator_tb.sv @@
module bitmap_id_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BITMAP_SIZE = bia_pkg::CAPACITY_DEF;
   localparam int unsigned RUN_LIMIT   = 1000000;
   localparam int unsigned HOLD_AFTER  = 40;    // responses before the long stall
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned RAND_PHASES = 11;
   localparam int unsigned PHASE_WORDS = 50;

   typedef struct {
      bia_pkg::action_type      action;
      logic [bia_pkg::ID_W-1:0] id;
   } id_request_type;

   typedef struct {
      logic [bia_pkg::ID_W-1:0] granted;
      bia_pkg::status_type      status;
   } id_outcome_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bia_pkg::ID_W-1:0]       req_tdata = '0;    // [15:0] release_id
   logic                           req_tuser = 1'b0;  // [0] action
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bia_pkg::ID_W-1:0]       rsp_tdata;         // [15:0] granted_id
   logic [bia_pkg::STATUS_W-1:0]   rsp_tuser;         // [1:0] status
   logic                           csr_we = 1'b0;
   logic [bia_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [bia_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state: bitmap and registers as the block should hold them
   bit                     id_used [BITMAP_SIZE];
   int unsigned            base_cfg = bia_pkg::BASE_RESET;
   int unsigned            count_cfg = bia_pkg::COUNT_RESET;

   id_request_type         pending_requests[$];
   id_outcome_type         expected_outcomes[$];
   int unsigned            errors = 0;
   int unsigned            cycles = 0;
   bit                     send_gaps_on = 1'b1;
   bit                     recv_gaps_on = 1'b1;
   int                     send_gap_left = 0;
   int                     recv_wait_left = 0;
   int unsigned            rsp_taken = 0;

   bitmap_id_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // number of identifiers actually served: clipped to capacity and to 16 bits
   function automatic int unsigned live_count();
      int unsigned n;
      n = count_cfg;
      if (n > BITMAP_SIZE) n = BITMAP_SIZE;
      if (n > 65536 - base_cfg) n = 65536 - base_cfg;
      return n;
   endfunction

   // lowest free bit on allocate, range check and clear on release
   function automatic id_outcome_type predict_outcome(bia_pkg::action_type act,
                                                      logic [bia_pkg::ID_W-1:0] rid);
      id_outcome_type res;
      int unsigned    n;
      int unsigned    r;
      bit             done;
      n = live_count();
      r = rid;
      done = 1'b0;
      res.granted = '0;
      if (act == bia_pkg::ACT_ALLOC) begin
         res.status = bia_pkg::STATUS_NO_FREE;
         for (int unsigned k = 0; k < n && !done; k++) begin
            if (!id_used[k]) begin
               id_used[k] = 1'b1;
               res.granted = bia_pkg::ID_W'(base_cfg + k);
               res.status = bia_pkg::STATUS_OK;
               done = 1'b1;
            end
         end
      end else if (r >= base_cfg && r - base_cfg < n) begin
         id_used[r - base_cfg] = 1'b0;
         res.status = bia_pkg::STATUS_OK;
      end else begin
         res.status = bia_pkg::STATUS_RANGE;
      end
      return res;
   endfunction

   function automatic int draw_wait(bit on);
      return on ? int'($urandom_range(0, 13)) : 0;
   endfunction

   task automatic queue_request(bia_pkg::action_type act, logic [bia_pkg::ID_W-1:0] id);
      id_request_type rq;
      rq.action = act;
      rq.id = id;
      pending_requests.push_back(rq);
   endtask

   task automatic write_reg(logic [bia_pkg::CSR_ADDR_W-1:0] idx,
                            logic [bia_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bia_pkg::CSR_BASE_ID) base_cfg = val;
      else count_cfg = val[bia_pkg::COUNT_REG_W-1:0];
   endtask

   // sender holds back until every outstanding word has been answered
   task automatic wait_drained();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      int             gap;
      id_request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap_left <= 0;
      end else begin
         gap = send_gap_left;
         if (req_tvalid && req_tready) gap = draw_wait(send_gaps_on);
         if (!req_tvalid || req_tready) begin
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap_left <= gap - 1;
            end else if (pending_requests.size() != 0) begin
               rq = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= rq.id;
               req_tuser <= rq.action;
               send_gap_left <= 0;
            end else begin
               req_tvalid <= 1'b0;
               send_gap_left <= 0;
            end
         end
      end
   end

   // response sink, with one long stall to back the block up
   always @(posedge clock) begin : drive_ready
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait_left <= 0;
      end else begin
         w = recv_wait_left;
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken <= rsp_taken + 1;
            w = (rsp_taken + 1 == HOLD_AFTER) ? LONG_HOLD : draw_wait(recv_gaps_on);
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            recv_wait_left <= w - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_wait_left <= 0;
         end
      end
   end

   // checker: responses against the oldest prediction, then log new requests
   always @(posedge clock) begin : check_results
      id_outcome_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected word, granted_id %0d status %0d",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_r = expected_outcomes.pop_front();
               if (rsp_tdata !== exp_r.granted) begin
                  $display("%0t: granted_id expected %0d, got %0d",
                           $time, exp_r.granted, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== exp_r.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, exp_r.status, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(
               predict_outcome(bia_pkg::action_type'(req_tuser), req_tdata));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned new_base;
      int unsigned new_count;
      int unsigned n;
      int unsigned k;
      int unsigned alloc_pct;
      logic [bia_pkg::ID_W-1:0] rid;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: first grants, release edges of the range
      queue_request(bia_pkg::ACT_ALLOC, 16'hFFFF);
      queue_request(bia_pkg::ACT_ALLOC, 16'h0000);
      queue_request(bia_pkg::ACT_RELEASE, 16'd300);
      queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
      queue_request(bia_pkg::ACT_RELEASE, 16'd299);
      queue_request(bia_pkg::ACT_RELEASE, 16'd5000);
      queue_request(bia_pkg::ACT_RELEASE, 16'd5001);
      queue_request(bia_pkg::ACT_RELEASE, 16'd0);
      queue_request(bia_pkg::ACT_RELEASE, 16'hFFFF);

      // count above capacity, range clipped at the top of the id space
      wait_drained();
      write_reg(bia_pkg::CSR_BASE_ID, 16'd65528);
      write_reg(bia_pkg::CSR_ID_COUNT, 16'd16383);
      @(negedge clock);
      repeat (9) queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
      queue_request(bia_pkg::ACT_RELEASE, 16'hFFFF);

      // single identifier at the very top; bitmap kept across the rewrite
      wait_drained();
      write_reg(bia_pkg::CSR_BASE_ID, 16'hFFFF);
      write_reg(bia_pkg::CSR_ID_COUNT, 16'd1);
      @(negedge clock);
      queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
      queue_request(bia_pkg::ACT_RELEASE, 16'hFFFF);
      queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));

      // zero count: nothing to grant, nothing in range
      wait_drained();
      write_reg(bia_pkg::CSR_ID_COUNT, 16'd0);
      @(negedge clock);
      queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
      queue_request(bia_pkg::ACT_RELEASE, 16'hFFFF);

      // full capacity from zero
      wait_drained();
      write_reg(bia_pkg::CSR_BASE_ID, 16'd0);
      write_reg(bia_pkg::CSR_ID_COUNT, 16'(BITMAP_SIZE));
      @(negedge clock);
      queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
      queue_request(bia_pkg::ACT_RELEASE, 16'(BITMAP_SIZE - 1));
      queue_request(bia_pkg::ACT_RELEASE, 16'(BITMAP_SIZE));

      // random phases, each under its own settings
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_drained();
         case ($urandom_range(0, 4))
            0:       new_base = 0;
            1:       new_base = $urandom_range(0, 65535);
            2:       new_base = 65535 - $urandom_range(0, 40);
            3:       new_base = $urandom_range(0, 1000);
            default: new_base = base_cfg;
         endcase
         case ($urandom_range(0, 7))
            0, 1, 2: new_count = $urandom_range(1, 16);
            3, 4:    new_count = $urandom_range(17, 200);
            5:       new_count = $urandom_range(201, BITMAP_SIZE);
            6:       new_count = $urandom_range(BITMAP_SIZE, 16383);
            default: new_count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
         endcase
         if ($urandom_range(0, 1)) begin
            write_reg(bia_pkg::CSR_BASE_ID, 16'(new_base));
            write_reg(bia_pkg::CSR_ID_COUNT, 16'(new_count));
         end else begin
            write_reg(bia_pkg::CSR_ID_COUNT, 16'(new_count));
            write_reg(bia_pkg::CSR_BASE_ID, 16'(new_base));
         end
         @(negedge clock);
         send_gaps_on = $urandom_range(0, 3) != 0;
         recv_gaps_on = $urandom_range(0, 3) != 0;
         alloc_pct = $urandom_range(30, 75);
         n = live_count();
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
               queue_request(bia_pkg::ACT_ALLOC, bia_pkg::ID_W'($urandom));
            end else begin
               // mostly ids likely granted already, some noise and edge misses
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5, 6: begin
                     if (n == 0) k = 0;
                     else if (n > 64 && $urandom_range(0, 1)) k = $urandom_range(0, 63);
                     else k = $urandom_range(0, n - 1);
                     rid = bia_pkg::ID_W'(base_cfg + k);
                  end
                  7:       rid = bia_pkg::ID_W'($urandom);
                  8:       rid = bia_pkg::ID_W'(base_cfg - 1);
                  default: rid = bia_pkg::ID_W'(base_cfg + n + $urandom_range(0, 4));
               endcase
               queue_request(bia_pkg::ACT_RELEASE, rid);
            end
         end
      end

      wait_drained();
      repeat (150) @(posedge clock);
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
